// File: src/jsi_pkg.sv
`default_nettype none

package jsi_pkg;

  // Widest word the datapath is built for; lanes at and above LANES stay zero
  localparam int MAX_LANES = 8;
  localparam int LANE_W    = 3;

  // Word queue between the scanner and the result emitter (power of two)
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int COUNT_W    = 3;

  // Character codes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;

  // Odd lane pattern for the backslash run scheme
  localparam logic [63:0] ODD_LANES = 64'hAAAAAAAAAAAAAAAA;

  // Per-word scan summary
  typedef struct packed {
    logic [MAX_LANES-1:0] hits;   // structural chars outside strings
    logic [MAX_LANES-1:0] smask;  // in-string mask
  } jsi_word_t;

  function automatic logic is_structural(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACKET) ||
           (c == CH_RBRACKET) || (c == CH_COLON) || (c == CH_COMMA);
  endfunction

endpackage

`default_nettype wire

// File: src/jsi_scan.sv
`default_nettype none

module jsi_scan
  import jsi_pkg::*;
#(
  parameter int LANES         = 8,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [63:0]              data_word,
  input  wire logic                     restart,
  input  wire logic                     accept,
  output jsi_word_t                     word_rec,
  output logic      [POSITION_BITS-1:0] word_base
);

  logic                     escape_carry;
  logic                     string_carry;
  logic [POSITION_BITS-1:0] byte_position;

  logic                     esc_in;
  logic                     str_in;
  logic [POSITION_BITS-1:0] pos_in;

  logic [LANES-1:0] quotes;
  logic [LANES-1:0] slashes;
  logic [LANES-1:0] structs;
  logic [LANES-1:0] odd;
  logic [LANES-1:0] potential;
  logic [LANES-1:0] code;
  logic [LANES-1:0] escaped;
  logic [LANES-1:0] escape;
  logic [LANES-1:0] unesc;
  logic [LANES-1:0] parity;
  logic [LANES-1:0] strm;
  logic [LANES-1:0] hits;
  logic             acc;

  // Restart drops the carried state for this word
  assign esc_in = restart ? 1'b0 : escape_carry;
  assign str_in = restart ? 1'b0 : string_carry;
  assign pos_in = restart ? '0 : byte_position;

  // Byte classification per lane
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      quotes[k]  = (data_word[8*k +: 8] == CH_QUOTE);
      slashes[k] = (data_word[8*k +: 8] == CH_BACKSLASH);
      structs[k] = is_structural(data_word[8*k +: 8]);
    end
  end

  // Backslash runs: an odd-length run of backslashes escapes the next byte
  assign odd       = LANES'(ODD_LANES);
  assign potential = slashes & ~LANES'(esc_in);
  assign code      = (((potential << 1) | odd) - potential) ^ odd;
  assign escaped   = code ^ (slashes | LANES'(esc_in));
  assign escape    = code & slashes;
  assign unesc     = quotes & ~escaped;

  // Prefix parity of unescaped quotes gives the string mask
  always_comb begin
    acc = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      acc       = acc ^ unesc[k];
      parity[k] = acc;
    end
  end

  assign strm = parity ^ {LANES{str_in}};
  assign hits = structs & ~strm;

  assign word_rec.hits  = MAX_LANES'(hits);
  assign word_rec.smask = MAX_LANES'(strm);
  assign word_base      = pos_in;

  // Carried state, updated per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_carry  <= 1'b0;
      string_carry  <= 1'b0;
      byte_position <= '0;
    end else if (accept) begin
      escape_carry  <= escape[LANES-1];
      string_carry  <= strm[LANES-1];
      byte_position <= pos_in + POSITION_BITS'(LANES);
    end
  end

endmodule

`default_nettype wire

// File: src/jsi_fifo.sv
`default_nettype none

module jsi_fifo
  import jsi_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire jsi_word_t                push_rec,
  input  wire logic [POSITION_BITS-1:0] push_base,
  input  wire logic                     pop,
  output jsi_word_t                     head_rec,
  output logic      [POSITION_BITS-1:0] head_base,
  output logic                          head_valid,
  output logic                          full
);

  jsi_word_t                recs  [FIFO_DEPTH];
  logic [POSITION_BITS-1:0] bases [FIFO_DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [COUNT_W-1:0]       count;
  logic                     do_push;
  logic                     do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == COUNT_W'(FIFO_DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head_rec   = recs[rd_ptr];
  assign head_base  = bases[rd_ptr];

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      recs[wr_ptr]  <= push_rec;
      bases[wr_ptr] <= push_base;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/jsi_emit.sv
`default_nettype none

module jsi_emit
  import jsi_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire jsi_word_t                head_rec,
  input  wire logic [POSITION_BITS-1:0] head_base,
  input  wire logic                     head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [31:0]              position,
  output logic                          position_valid,
  output logic      [MAX_LANES-1:0]     string_mask,
  output logic                          last_of_item
);

  logic [MAX_LANES-1:0]     done;
  logic [MAX_LANES-1:0]     remaining;
  logic [MAX_LANES-1:0]     low_bit;
  logic [MAX_LANES-1:0]     rest;
  logic [LANE_W-1:0]        lane;
  logic                     any;
  logic                     last;
  logic                     out_free;
  logic                     fire;
  logic [POSITION_BITS-1:0] pos_sum;

  // Lowest structural lane not yet sent
  assign remaining = head_rec.hits & ~done;
  always_comb begin
    lane = '0;
    for (int k = MAX_LANES - 1; k >= 0; k--) begin
      if (remaining[k]) lane = LANE_W'(k);
    end
  end

  assign low_bit  = MAX_LANES'(1) << lane;
  assign rest     = remaining & ~low_bit;
  assign any      = |remaining;
  assign last     = (rest == '0);
  assign out_free = !out_valid || out_ready;
  assign fire     = head_valid && out_free;
  assign pop      = fire && last;
  assign pos_sum  = head_base + POSITION_BITS'(lane);

  // Sent-lane tracking for the head word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (fire) begin
      done <= last ? '0 : (done | low_bit);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      position       <= any ? 32'(pos_sum) : 32'd0;
      position_valid <= any;
      string_mask    <= head_rec.smask;
      last_of_item   <= last;
    end
  end

endmodule

`default_nettype wire

// File: src/json_structural_indexer.sv
`default_nettype none

// JSON structural character indexer.
// Input channel (in_valid/in_ready): one request carries an 8-byte text word,
// earliest byte in bits 7..0, plus restart, which zeroes the escape carry,
// string carry and byte position before that word is scanned.
// Output channel (out_valid/out_ready): one request per structural character
// ({ } [ ] : ,) found outside strings, in byte order, with its absolute
// position, the word's string mask, and last_of_item on the word's final
// request. A word with no structural character yields one request with
// position_valid low.
// A word accepted into the queue is registered there, then in the output
// register when it reaches the head. Input: one word per cycle while in_ready
// is high, into a 4-entry word queue; results leave at one per cycle while
// out_ready is high, so a word with n hits yields max(1, n) results and the
// queue absorbs bursts. in_ready drops only when the queue is full.
// Receiver stall: the output register holds its request; the queue fills and
// then backpressures the input. Reset (rst, synchronous) empties the queue,
// clears the output register and zeroes all carried state.
module json_structural_indexer
  import jsi_pkg::*;
#(
  parameter int LANES         = 8,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] data_word,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] position,
  output logic             position_valid,
  output logic      [7:0]  string_mask,
  output logic             last_of_item
);

  jsi_word_t                scan_rec;
  logic [POSITION_BITS-1:0] scan_base;
  jsi_word_t                head_rec;
  logic [POSITION_BITS-1:0] head_base;
  logic                     head_valid;
  logic                     full;
  logic                     pop;
  logic                     accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  jsi_scan #(
    .LANES         (LANES),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .data_word (data_word),
    .restart   (restart),
    .accept    (accept),
    .word_rec  (scan_rec),
    .word_base (scan_base)
  );

  jsi_fifo #(
    .POSITION_BITS (POSITION_BITS)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_rec   (scan_rec),
    .push_base  (scan_base),
    .pop        (pop),
    .head_rec   (head_rec),
    .head_base  (head_base),
    .head_valid (head_valid),
    .full       (full)
  );

  jsi_emit #(
    .POSITION_BITS (POSITION_BITS)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .head_rec       (head_rec),
    .head_base      (head_base),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .position       (position),
    .position_valid (position_valid),
    .string_mask    (string_mask),
    .last_of_item   (last_of_item)
  );

endmodule

`default_nettype wire

// File: src/jsi_checker.sv
`default_nettype none

module jsi_checker #(
  parameter int LANES = 8
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [63:0] data_word,
  input wire logic        restart,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] position,
  input wire logic        position_valid,
  input wire logic [7:0]  string_mask,
  input wire logic        last_of_item
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // A waiting input request keeps valid and payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_word) && $stable(restart))
    else $error("input request changed while waiting");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) &&
      $stable(position_valid) && $stable(string_mask) && $stable(last_of_item))
    else $error("stalled result changed");

  // An empty-word result stands alone and carries position zero
  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_valid |-> last_of_item && (position == 32'd0))
    else $error("empty-word result not last or nonzero position");

  // Lanes beyond LANES never show in the string mask
  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((string_mask >> LANES) == 8'd0))
    else $error("string mask bit above lane count");

endmodule

bind json_structural_indexer jsi_checker #(.LANES(LANES)) u_jsi_checker (.*);

`default_nettype wire
